// ===== rtl/nlj_pkg.sv =====
// Package for the nested loop join engine: word types, status and action codes,
// store sizes and derived widths. No dependencies.
`timescale 1ns / 1ps

package nlj_pkg;

  localparam int OUTER_ROWS = 256;
  localparam int INNER_ROWS = 256;

  // row index and count widths (a count must also hold the full size)
  localparam int OIDX_W = (OUTER_ROWS > 1) ? $clog2(OUTER_ROWS) : 1;
  localparam int IIDX_W = (INNER_ROWS > 1) ? $clog2(INNER_ROWS) : 1;
  localparam int OCNT_W = $clog2(OUTER_ROWS + 1);
  localparam int ICNT_W = $clog2(INNER_ROWS + 1);

  localparam logic [1:0] ACT_LOAD_OUTER = 2'd0;
  localparam logic [1:0] ACT_LOAD_INNER = 2'd1;
  localparam logic [1:0] ACT_NEXT       = 2'd2;
  localparam logic [1:0] ACT_CLEAR      = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_MATCH     = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  localparam logic [1:0] MODE_CROSS = 2'd0;
  localparam logic [1:0] MODE_EQ    = 2'd1;
  localparam logic [1:0] MODE_NE    = 2'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] row_id;
    logic [63:0] row_key;
    logic [63:0] row_payload;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] match_rid;
    logic [63:0] outer_key;
    logic [63:0] outer_data;
    logic [63:0] inner_key;
    logic [63:0] inner_data;
  } out_word_t;

  typedef struct packed {
    logic [31:0] rid;
    logic [63:0] key;
    logic [63:0] pay;
  } outer_row_t;

  typedef struct packed {
    logic [63:0] key;
    logic [63:0] pay;
  } inner_row_t;

endpackage

// ===== rtl/nlj_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module nlj_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/nlj_key_cmp.sv =====
// Key compare unit: applies the join's compare mode to one key pair.
// Depends on nlj_pkg.
`timescale 1ns / 1ps

module nlj_key_cmp (
  input  logic [1:0]  mode,
  input  logic [63:0] key_a,
  input  logic [63:0] key_b,
  output logic        match
);
  import nlj_pkg::*;

  logic eq;

  assign eq = (key_a == key_b);

  always_comb begin
    unique case (mode)
      MODE_CROSS: match = 1'b1;
      MODE_NE:    match = !eq;
      default:    match = eq;  // equality mode, and the unused code
    endcase
  end

endmodule

// ===== rtl/nested_loop_join_engine.sv =====
// Nested loop join engine. The result word of a load or clear is
// registered and valid the cycle after the input word is taken.
// A next request walks the inner rows for each outer row, reading a pair from
// the RAMs in S_SCAN and comparing keys in S_CMP. One word at a time: in_ready
// stays low until the result word has gone, so a new word is not taken while
// a result is still held.
// Synchronous active-low reset empties both stores, rewinds the cursors and
// sets the compare mode to keys-equal; no clearing pass is needed.
`timescale 1ns / 1ps

module nested_loop_join_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  nlj_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_ready,
  output nlj_pkg::out_word_t out_word,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);
  import nlj_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,   // taking words
    S_SCAN,   // check cursors, issue RAM reads
    S_CMP     // read data back, compare keys
  } state_t;

  state_t              state_r;
  logic [1:0]          compare_mode_r;
  logic [OCNT_W-1:0]   outer_count_r;
  logic [ICNT_W-1:0]   inner_count_r;
  logic [OCNT_W-1:0]   outer_cursor_r;
  logic [ICNT_W-1:0]   inner_cursor_r;
  logic                out_valid_r;
  out_word_t           out_word_r;

  logic       accept;
  logic       outer_full;
  logic       inner_full;
  logic       outer_we;
  logic       inner_we;
  outer_row_t outer_wr;
  inner_row_t inner_wr;
  outer_row_t outer_rd;
  inner_row_t inner_rd;
  logic       key_match;

  // result word carrying only a status; row fields zero
  function automatic out_word_t status_word(logic [1:0] st);
    out_word_t w;
    w        = '0;
    w.status = st;
    return w;
  endfunction

  assign in_ready = (state_r == S_IDLE) && !out_valid_r;
  assign accept   = in_valid && in_ready;

  assign outer_full = (outer_count_r == OCNT_W'(OUTER_ROWS));
  assign inner_full = (inner_count_r == ICNT_W'(INNER_ROWS));

  // loads append at the current count
  assign outer_we = accept && (in_word.action == ACT_LOAD_OUTER) && !outer_full;
  assign inner_we = accept && (in_word.action == ACT_LOAD_INNER) && !inner_full;

  assign outer_wr.rid = in_word.row_id;
  assign outer_wr.key = in_word.row_key;
  assign outer_wr.pay = in_word.row_payload;
  assign inner_wr.key = in_word.row_key;
  assign inner_wr.pay = in_word.row_payload;

  // Reads always follow the cursors; the pair read in S_SCAN is
  // compared in S_CMP.
  nlj_ram #(
    .WIDTH ($bits(outer_row_t)),
    .DEPTH (OUTER_ROWS)
  ) u_outer_ram (
    .clk   (clk),
    .we    (outer_we),
    .waddr (outer_count_r[OIDX_W-1:0]),
    .wdata (outer_wr),
    .raddr (outer_cursor_r[OIDX_W-1:0]),
    .rdata (outer_rd)
  );

  nlj_ram #(
    .WIDTH ($bits(inner_row_t)),
    .DEPTH (INNER_ROWS)
  ) u_inner_ram (
    .clk   (clk),
    .we    (inner_we),
    .waddr (inner_count_r[IIDX_W-1:0]),
    .wdata (inner_wr),
    .raddr (inner_cursor_r[IIDX_W-1:0]),
    .rdata (inner_rd)
  );

  nlj_key_cmp u_cmp (
    .mode  (compare_mode_r),
    .key_a (outer_rd.key),
    .key_b (inner_rd.key),
    .match (key_match)
  );

  // Sequencer, counts, cursors and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      compare_mode_r <= MODE_EQ;
      outer_count_r  <= '0;
      inner_count_r  <= '0;
      outer_cursor_r <= '0;
      inner_cursor_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        compare_mode_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            unique case (in_word.action)
              ACT_LOAD_OUTER: begin
                out_valid_r <= 1'b1;
                out_word_r  <= status_word(outer_full ? ST_FULL : ST_DONE);
                if (!outer_full) begin
                  outer_count_r <= outer_count_r + 1'b1;
                end
              end
              ACT_LOAD_INNER: begin
                out_valid_r <= 1'b1;
                out_word_r  <= status_word(inner_full ? ST_FULL : ST_DONE);
                if (!inner_full) begin
                  inner_count_r <= inner_count_r + 1'b1;
                end
              end
              ACT_NEXT: begin
                state_r <= S_SCAN;
              end
              default: begin  // clear all
                out_valid_r    <= 1'b1;
                out_word_r     <= status_word(ST_DONE);
                outer_count_r  <= '0;
                inner_count_r  <= '0;
                outer_cursor_r <= '0;
                inner_cursor_r <= '0;
              end
            endcase
          end
        end

        S_SCAN: begin
          priority if (outer_cursor_r >= outer_count_r) begin
            // walk done; cursors rest here
            out_word_r  <= status_word(ST_EXHAUSTED);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else if (inner_cursor_r >= inner_count_r) begin
            outer_cursor_r <= outer_cursor_r + 1'b1;
            inner_cursor_r <= '0;
          end else begin
            // RAMs latch the current pair at this edge
            inner_cursor_r <= inner_cursor_r + 1'b1;
            state_r        <= S_CMP;
          end
        end

        S_CMP: begin
          if (key_match) begin
            out_word_r  <= {ST_MATCH, outer_rd.rid, outer_rd.key, outer_rd.pay,
                            inner_rd.key, inner_rd.pay};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_SCAN;
          end
        end

        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // cursors never run past the fill counts
  a_outer_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    outer_cursor_r <= outer_count_r)
    else $error("outer cursor past outer count");

  a_inner_cursor: assert property (@(posedge clk) disable iff (!rst_n)
    inner_cursor_r <= inner_count_r)
    else $error("inner cursor past inner count");

  // no result is held while the walk is in progress
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending during scan");

  // only a match carries row data
  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_word_r.status != ST_MATCH)) |->
      ((out_word_r.match_rid == '0) && (out_word_r.outer_key == '0) &&
       (out_word_r.inner_key == '0)))
    else $error("non-match result carries data");

endmodule
